// File: rtl/cfb_pkg.sv
// -----------------------------------------------------------------------------
// cfb_pkg
// Shared types and constants for the clipped frame-buffer alpha blender.
// -----------------------------------------------------------------------------
package cfb_pkg;

	// frame geometry
	localparam int FRAME_WIDTH  = 256;
	localparam int FRAME_HEIGHT = 256;
	localparam int STORE_DEPTH  = FRAME_WIDTH * FRAME_HEIGHT;
	localparam int ADDR_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

	// field widths
	localparam int PIX_W   = 32;
	localparam int COORD_W = 16;
	localparam int CLIP_W  = 9;
	localparam int KIND_W  = 2;
	localparam int APB_AW  = 4;
	localparam int APB_DW  = 32;

	// item kinds; bit 1 set means a read (kind three included)
	localparam logic [KIND_W-1:0] KIND_BLEND   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REPLACE = 2'd1;
	localparam int                KIND_READ_BIT = 1;

	// register indexes
	localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
	localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
	localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

	// blend masks
	localparam logic [PIX_W-1:0] RB_MASK   = 32'h00ff00ff;
	localparam logic [PIX_W-1:0] G_MASK    = 32'h0000ff00;
	localparam logic [8:0]       ALPHA_ONE = 9'h100;

	typedef struct packed {
		logic [CLIP_W-1:0] left;
		logic [CLIP_W-1:0] top;
		logic [CLIP_W-1:0] right;
		logic [CLIP_W-1:0] bottom;
	} clip_regs_t;

endpackage

// File: rtl/cfb_ram.sv
// -----------------------------------------------------------------------------
// cfb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// -----------------------------------------------------------------------------
module cfb_ram #(
	parameter  int WIDTH = 32,
	parameter  int DEPTH = 1024,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/cfb_cfg.sv
// -----------------------------------------------------------------------------
// cfb_cfg
// APB register file holding the clip rectangle.
// -----------------------------------------------------------------------------
module cfb_cfg
	import cfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output clip_regs_t        clip
);

	clip_regs_t   clip_q;
	logic         wr_en;
	logic [1:0]   idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.left   <= '0;
			clip_q.top    <= '0;
			clip_q.right  <= CLIP_W'(256);
			clip_q.bottom <= CLIP_W'(256);
		end else if (wr_en) begin
			case (idx)
				REG_CLIP_LEFT:   clip_q.left   <= pwdata[CLIP_W-1:0];
				REG_CLIP_TOP:    clip_q.top    <= pwdata[CLIP_W-1:0];
				REG_CLIP_RIGHT:  clip_q.right  <= pwdata[CLIP_W-1:0];
				REG_CLIP_BOTTOM: clip_q.bottom <= pwdata[CLIP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_CLIP_LEFT:   prdata = APB_DW'(clip_q.left);
			REG_CLIP_TOP:    prdata = APB_DW'(clip_q.top);
			REG_CLIP_RIGHT:  prdata = APB_DW'(clip_q.right);
			REG_CLIP_BOTTOM: prdata = APB_DW'(clip_q.bottom);
			default:         prdata = '0;
		endcase
	end

	assign clip = clip_q;

endmodule

// File: rtl/cfb_blend.sv
// -----------------------------------------------------------------------------
// cfb_blend
// Source-over blend: products registered, then sums and repack.
// -----------------------------------------------------------------------------
module cfb_blend
	import cfb_pkg::*;
(
	input  logic             clk,
	input  logic             load,
	input  logic [PIX_W-1:0] old_pixel,
	input  logic [PIX_W-1:0] src_colour,
	output logic [PIX_W-1:0] held_pixel,
	output logic [PIX_W-1:0] blended
);

	logic [7:0]       ta;
	logic [PIX_W-1:0] drb;
	logic [PIX_W-1:0] dg;

	logic [PIX_W-1:0] old_s2;
	logic [7:0]       ta_s2;
	logic [PIX_W-1:0] prod_rb_s2;
	logic [PIX_W-1:0] prod_g_s2;
	logic [15:0]      prod_a_s2;

	logic [PIX_W-1:0] rb_sum;
	logic [PIX_W-1:0] g_sum;
	logic [7:0]       a_sum;

	assign ta  = src_colour[31:24];
	// differences wrap mod 2^32
	assign drb = (src_colour & RB_MASK) - (old_pixel & RB_MASK);
	assign dg  = (src_colour & G_MASK) - (old_pixel & G_MASK);

	always_ff @(posedge clk) begin
		if (load) begin
			old_s2     <= old_pixel;
			ta_s2      <= ta;
			prod_rb_s2 <= PIX_W'(drb * PIX_W'(ta));
			prod_g_s2  <= PIX_W'(dg * PIX_W'(ta));
			prod_a_s2  <= 16'(16'(old_pixel[31:24]) * (16'(ALPHA_ONE) - 16'(ta)));
		end
	end

	assign rb_sum = (old_s2 & RB_MASK) + (prod_rb_s2 >> 8);
	assign g_sum  = (old_s2 & G_MASK) + (prod_g_s2 >> 8);
	assign a_sum  = ta_s2 + prod_a_s2[15:8];

	assign blended    = (rb_sum & RB_MASK) | (g_sum & G_MASK) | {a_sum, 24'h000000};
	assign held_pixel = old_s2;

endmodule

// File: rtl/clipped_framebuffer_alpha_blender_top.sv
// -----------------------------------------------------------------------------
// clipped_framebuffer_alpha_blender_top
// Frame store with clipped pixel writes, source-over blending and reads.
// -----------------------------------------------------------------------------
//
//  channel   dir  transfer when                payload
//  s_axis    in   s_axis_tvalid & tready       tdata: pos_x, pos_y, colour;
//                                              tuser: kind
//  m_axis    out  m_axis_tvalid & tready       tdata: pixel; tuser: clipped
//  apb       in   psel & penable & pwrite      clip rectangle registers
//
//  Flow: one item in flight; the store read and the multiply stage are
//  registered, then the sum goes to the output register, and the next item is
//  taken once the previous item has left stage 2. The read-modify-write
//  through the frame store sets this: read, multiply stage, sum, write back.
//  Reset: the store is cleared by a pass over all STORE_DEPTH words (65536 at the
//  default geometry), one word a cycle; s_axis_tready stays low until done.
//  Stalls: a held result sits in the output register and the next item is
//  still accepted; stage 2 waits only while that register is full and not
//  taken. Write-back lands before the next read, so no forwarding is needed.
// -----------------------------------------------------------------------------
module clipped_framebuffer_alpha_blender_top
	import cfb_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [63:0]       s_axis_tdata,  // [15:0] pos_x, [31:16] pos_y, [63:32] colour
	input  logic [KIND_W-1:0] s_axis_tuser,  // [1:0] kind

	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [PIX_W-1:0]  m_axis_tdata,  // [31:0] pixel
	output logic              m_axis_tuser,  // [0] clipped

	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	clip_regs_t clip;

	// input decode
	logic [COORD_W-1:0] pos_x, pos_y;
	logic [PIX_W-1:0]   colour;
	logic [COORD_W-1:0] ux, uy;
	logic               x_in_frame, y_in_frame, x_in_clip, y_in_clip;
	logic               item_ok;
	logic [31:0]        addr_full;
	logic [ADDR_W-1:0]  in_addr;
	logic               in_go;

	// clearing pass
	logic               clear_q;
	logic [ADDR_W-1:0]  clr_cnt_q;

	// pipeline
	logic                s1_v_q, s2_v_q;
	logic [KIND_W-1:0]   kind_s1, kind_s2;
	logic [PIX_W-1:0]    colour_s1, colour_s2;
	logic [ADDR_W-1:0]   addr_s1, addr_s2;
	logic                ok_s1, ok_s2;
	logic                s2_go;
	logic [PIX_W-1:0]    result_s2;
	logic                is_read_s2;

	// store and blend
	logic [PIX_W-1:0]    rd_data;
	logic [PIX_W-1:0]    held_pixel, blended;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [PIX_W-1:0]    ram_wdata;

	// output register
	logic                out_v_q;
	logic [PIX_W-1:0]    out_pix_q;
	logic                out_clip_q;

	cfb_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.clip    (clip)
	);

	assign pos_x  = s_axis_tdata[15:0];
	assign pos_y  = s_axis_tdata[31:16];
	assign colour = s_axis_tdata[63:32];

	// negative coordinates fail the frame test, so only the low 15 bits matter
	assign ux = {1'b0, pos_x[COORD_W-2:0]};
	assign uy = {1'b0, pos_y[COORD_W-2:0]};

	assign x_in_frame = !pos_x[COORD_W-1] && (ux < COORD_W'(FRAME_WIDTH));
	assign y_in_frame = !pos_y[COORD_W-1] && (uy < COORD_W'(FRAME_HEIGHT));
	assign x_in_clip  = (ux >= COORD_W'(clip.left)) && (ux < COORD_W'(clip.right));
	assign y_in_clip  = (uy >= COORD_W'(clip.top)) && (uy < COORD_W'(clip.bottom));

	// reads ignore the clip rectangle
	assign item_ok = x_in_frame && y_in_frame &&
	                 (s_axis_tuser[KIND_READ_BIT] || (x_in_clip && y_in_clip));

	assign addr_full = 32'(uy) * 32'(FRAME_WIDTH) + 32'(ux);
	assign in_addr   = addr_full[ADDR_W-1:0];

	// one item at a time; stage 2 write lands before the next read is issued
	assign s_axis_tready = !clear_q && !s1_v_q && !s2_v_q;
	assign in_go         = s_axis_tvalid && s_axis_tready;

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_q   <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clear_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == ADDR_W'(STORE_DEPTH - 1)) begin
				clear_q <= 1'b0;
			end
		end
	end

	// valid bits
	assign s2_go = s2_v_q && (!out_v_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			s1_v_q <= in_go;
			if (s1_v_q) begin
				s2_v_q <= 1'b1;
			end else if (s2_go) begin
				s2_v_q <= 1'b0;
			end
			if (s2_go) begin
				out_v_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// payload stages
	always_ff @(posedge clk) begin
		if (in_go) begin
			kind_s1   <= s_axis_tuser;
			colour_s1 <= colour;
			addr_s1   <= in_addr;
			ok_s1     <= item_ok;
		end
		if (s1_v_q) begin
			kind_s2   <= kind_s1;
			colour_s2 <= colour_s1;
			addr_s2   <= addr_s1;
			ok_s2     <= ok_s1;
		end
		if (s2_go) begin
			out_pix_q  <= result_s2;
			out_clip_q <= !ok_s2;
		end
	end

	cfb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (in_addr),
		.rdata (rd_data)
	);

	cfb_blend u_blend (
		.clk        (clk),
		.load       (s1_v_q),
		.old_pixel  (rd_data),
		.src_colour (colour_s1),
		.held_pixel (held_pixel),
		.blended    (blended)
	);

	assign is_read_s2 = kind_s2[KIND_READ_BIT];

	always_comb begin
		if (!ok_s2) begin
			result_s2 = '0;
		end else if (is_read_s2) begin
			result_s2 = held_pixel;
		end else if (kind_s2 == KIND_REPLACE) begin
			result_s2 = colour_s2;
		end else if (kind_s2 == KIND_BLEND) begin
			result_s2 = blended;
		end else begin
			result_s2 = held_pixel;
		end
	end

	// write back once, as the result moves to the output register
	assign ram_we    = clear_q || (s2_go && ok_s2 && !is_read_s2);
	assign ram_waddr = clear_q ? clr_cnt_q : addr_s2;
	assign ram_wdata = clear_q ? '0 : result_s2;

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_pix_q;
	assign m_axis_tuser  = out_clip_q;

endmodule

// File: tb/clipped_framebuffer_alpha_blender_top_tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// clipped_framebuffer_alpha_blender_top_tb
// Self-checking bench for the clipped frame-buffer blender. A short table of
// draw and read items runs first, then random phases, each under its own clip
// rectangle. Every accepted item goes through a local mirror of the frame
// store and clip registers, and each result transfer is compared with the
// oldest predicted pixel.
// -----------------------------------------------------------------------------
module clipped_framebuffer_alpha_blender_top_tb;
	import cfb_pkg::*;

	// read kinds: bit 1 selects a read, kind three decodes the same way
	localparam logic [KIND_W-1:0] KIND_READ       = KIND_W'(1 << KIND_READ_BIT);
	localparam logic [KIND_W-1:0] KIND_READ_ALIAS = KIND_READ | KIND_REPLACE;

	localparam int GAP_MAX      = 11;   // longest idle per item on either side
	localparam int DRAIN_CYCLES = 16;   // wait after the last result before the verdict
	// the clearing pass after reset is the longest quiet stretch by far
	localparam int WATCHDOG_LIMIT = 4 * (STORE_DEPTH + 1000);
	localparam int PHASE_COUNT  = 8;
	localparam int PHASE_ITEMS  = 160;
	localparam int HOT_COUNT    = 6;
	localparam int DIR_COUNT    = 24;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             clipped;
	} pix_res_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [PIX_W-1:0]   colour;
		logic               typed;        // expected result given in the row
		logic [PIX_W-1:0]   exp_pixel;
		logic               exp_clipped;
	} draw_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              s_axis_tvalid = 1'b0;
	logic              s_axis_tready;
	logic [63:0]       s_axis_tdata = '0;   // [15:0] pos_x, [31:16] pos_y, [63:32] colour
	logic [KIND_W-1:0] s_axis_tuser = '0;   // [1:0] kind
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [PIX_W-1:0]  m_axis_tdata;        // [31:0] pixel
	logic              m_axis_tuser;        // [0] clipped
	logic              psel = 1'b0;
	logic              penable = 1'b0;
	logic              pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	logic [APB_DW-1:0] prdata;
	logic              pready;

	// mirror of the block's state
	logic [PIX_W-1:0] frame_mirror [STORE_DEPTH];
	clip_regs_t       clip_mirror;
	pix_res_t         pix_expect_q [$];

	int mismatch_count = 0;
	int quiet_cycles = 0;
	bit src_steady;   // source sends back to back
	bit snk_steady;   // sink never stalls

	logic [COORD_W-1:0] hot_x [HOT_COUNT];
	logic [COORD_W-1:0] hot_y [HOT_COUNT];

	// Directed items. Coordinates are 16-bit two's complement:
	// ffff = -1, fffb = -5, 8000 = most negative, 7fff = most positive.
	draw_row_t dir_tab [DIR_COUNT] = '{
		// fresh store reads zero at both corners
		'{KIND_READ,       16'h0000, 16'h0000, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
		'{KIND_READ,       16'h00ff, 16'h00ff, 32'h00000000, 1'b1, 32'h00000000, 1'b0},
		// reads outside the frame on each side
		'{KIND_READ,       16'hffff, 16'h0000, 32'hffffffff, 1'b1, 32'h00000000, 1'b1},
		'{KIND_READ,       16'h0100, 16'h0000, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
		'{KIND_READ,       16'h0000, 16'h8000, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
		'{KIND_READ,       16'h7fff, 16'h7fff, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
		// replace then read back
		'{KIND_REPLACE,    16'h0000, 16'h0000, 32'hffffffff, 1'b1, 32'hffffffff, 1'b0},
		'{KIND_READ,       16'h0000, 16'h0000, 32'h00000000, 1'b1, 32'hffffffff, 1'b0},
		// zero and full source alpha
		'{KIND_BLEND,      16'h0000, 16'h0000, 32'h00000000, 1'b0, 32'h00000000, 1'b0},
		'{KIND_BLEND,      16'h0000, 16'h0000, 32'hff000000, 1'b0, 32'h00000000, 1'b0},
		'{KIND_BLEND,      16'h0001, 16'h0000, 32'hff123456, 1'b0, 32'h00000000, 1'b0},
		// chained blends on the far corner, back to back
		'{KIND_REPLACE,    16'h00ff, 16'h00ff, 32'h80808080, 1'b1, 32'h80808080, 1'b0},
		'{KIND_BLEND,      16'h00ff, 16'h00ff, 32'h40ff00ff, 1'b0, 32'h00000000, 1'b0},
		'{KIND_BLEND,      16'h00ff, 16'h00ff, 32'hc000ff00, 1'b0, 32'h00000000, 1'b0},
		'{KIND_READ_ALIAS, 16'h00ff, 16'h00ff, 32'h00000000, 1'b0, 32'h00000000, 1'b0},
		'{KIND_READ_ALIAS, 16'hfffb, 16'h0003, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
		// writes outside the frame are dropped
		'{KIND_BLEND,      16'hffff, 16'hffff, 32'hffffffff, 1'b1, 32'h00000000, 1'b1},
		'{KIND_REPLACE,    16'h0100, 16'h000a, 32'h12345678, 1'b1, 32'h00000000, 1'b1},
		'{KIND_BLEND,      16'h000a, 16'h0100, 32'hffffffff, 1'b1, 32'h00000000, 1'b1},
		'{KIND_REPLACE,    16'h8000, 16'h8000, 32'hffffffff, 1'b1, 32'h00000000, 1'b1},
		'{KIND_REPLACE,    16'h7fff, 16'h0000, 32'hffffffff, 1'b1, 32'h00000000, 1'b1},
		// read-modify-write hazard on one pixel
		'{KIND_BLEND,      16'h0005, 16'h0005, 32'hff0000ff, 1'b0, 32'h00000000, 1'b0},
		'{KIND_BLEND,      16'h0005, 16'h0005, 32'h7f00ff00, 1'b0, 32'h00000000, 1'b0},
		'{KIND_READ,       16'h0005, 16'h0005, 32'h00000000, 1'b0, 32'h00000000, 1'b0}
	};

	clipped_framebuffer_alpha_blender_top uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Packed source-over: red/blue and green lerped by top alpha with 32-bit
	// wrap, alpha accumulated as ta + ba*(256-ta)/256.
	function automatic logic [PIX_W-1:0] blend_source_over(input logic [PIX_W-1:0] under,
			input logic [PIX_W-1:0] over);
		logic [PIX_W-1:0] rb, g, diff, prod, ta32;
		int ta, ba, a;
		ta = int'(over[31:24]);
		ba = int'(under[31:24]);
		ta32 = PIX_W'(ta);
		rb = under & RB_MASK;
		g = under & G_MASK;
		diff = (over & RB_MASK) - rb;
		prod = diff * ta32;
		rb = rb + (prod >> 8);
		diff = (over & G_MASK) - g;
		prod = diff * ta32;
		g = g + (prod >> 8);
		a = ta + ((ba * (int'(ALPHA_ONE) - ta)) >> 8);
		return (rb & RB_MASK) | (g & G_MASK) | {a[7:0], 24'd0};
	endfunction

	// Expected result of one item; updates the store mirror on a passing write.
	function automatic pix_res_t predict_draw(input logic [KIND_W-1:0] kind,
			input logic [COORD_W-1:0] xr, input logic [COORD_W-1:0] yr,
			input logic [PIX_W-1:0] colour);
		int x, y, addr;
		bit in_frame, in_clip;
		pix_res_t r;
		x = int'($signed(xr));
		y = int'($signed(yr));
		in_frame = x >= 0 && x < FRAME_WIDTH && y >= 0 && y < FRAME_HEIGHT;
		in_clip = x >= int'(clip_mirror.left) && x < int'(clip_mirror.right) &&
			y >= int'(clip_mirror.top) && y < int'(clip_mirror.bottom);
		r = '{pixel: '0, clipped: 1'b1};
		addr = y * FRAME_WIDTH + x;
		if (kind[KIND_READ_BIT]) begin
			// reads ignore the clip rectangle
			if (in_frame) begin
				r.pixel = frame_mirror[addr];
				r.clipped = 1'b0;
			end
		end else if (in_frame && in_clip) begin
			r.pixel = (kind == KIND_BLEND) ? blend_source_over(frame_mirror[addr], colour)
				: colour;
			frame_mirror[addr] = r.pixel;
			r.clipped = 1'b0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [PIX_W-1:0] got,
			input logic [PIX_W-1:0] want);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("mismatch %0d at %0t: %s got %h want %h", mismatch_count, $time,
				what, got, want);
	endtask

	// One input transfer after a random gap; the prediction is queued once
	// the item is taken.
	task automatic send_draw(input logic [KIND_W-1:0] kind, input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [PIX_W-1:0] colour,
			input bit typed, input pix_res_t typed_res);
		int gap;
		pix_res_t r;
		gap = src_steady ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {colour, y, x};
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		r = predict_draw(kind, x, y, colour);
		pix_expect_q.push_back(typed ? typed_res : r);
	endtask

	// APB write: setup cycle, then access until pready.
	task automatic write_clip_reg(input logic [1:0] idx, input logic [CLIP_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= APB_DW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		case (idx)
			REG_CLIP_LEFT:   clip_mirror.left = value;
			REG_CLIP_TOP:    clip_mirror.top = value;
			REG_CLIP_RIGHT:  clip_mirror.right = value;
			REG_CLIP_BOTTOM: clip_mirror.bottom = value;
			default: ;
		endcase
	endtask

	// New clip rectangle, only once every result is back.
	task automatic program_clip(input int cl, input int ct, input int cr, input int cb);
		while (pix_expect_q.size() != 0) @(posedge clk);
		write_clip_reg(REG_CLIP_LEFT, CLIP_W'(cl));
		write_clip_reg(REG_CLIP_TOP, CLIP_W'(ct));
		write_clip_reg(REG_CLIP_RIGHT, CLIP_W'(cr));
		write_clip_reg(REG_CLIP_BOTTOM, CLIP_W'(cb));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// Coordinate on one axis: mostly inside the frame, some on clip and frame
	// edges, some anywhere in the 16-bit range.
	function automatic logic [COORD_W-1:0] pick_axis(input int lo, input int hi,
			input int span);
		int v;
		case ($urandom_range(0, 5))
			0, 1, 2: v = $urandom_range(0, span - 1);
			3: begin
				case ($urandom_range(0, 3))
					0: v = lo - 1;
					1: v = lo;
					2: v = hi - 1;
					default: v = hi;
				endcase
			end
			4: begin
				case ($urandom_range(0, 3))
					0: v = -1;
					1: v = 0;
					2: v = span - 1;
					default: v = span;
				endcase
			end
			default: v = int'($urandom);
		endcase
		return COORD_W'(v);
	endfunction

	// Coordinate inside the clip window where there is one.
	function automatic logic [COORD_W-1:0] pick_inside(input int lo, input int hi,
			input int span);
		int top_end;
		top_end = (hi < span) ? hi : span;
		if (lo < top_end)
			return COORD_W'($urandom_range(lo, top_end - 1));
		return COORD_W'($urandom_range(0, span - 1));
	endfunction

	task automatic run_phase(input int items);
		logic [KIND_W-1:0]  kind;
		logic [COORD_W-1:0] x, y;
		logic [PIX_W-1:0]   colour;
		int h;
		// a few hot pixels per phase so blends chain and reads see the writes
		for (int i = 0; i < HOT_COUNT; i++) begin
			hot_x[i] = pick_inside(int'(clip_mirror.left), int'(clip_mirror.right), FRAME_WIDTH);
			hot_y[i] = pick_inside(int'(clip_mirror.top), int'(clip_mirror.bottom), FRAME_HEIGHT);
		end
		for (int n = 0; n < items; n++) begin
			kind = KIND_W'($urandom_range(0, 3));
			if ($urandom_range(0, 9) < 4) begin
				h = $urandom_range(0, HOT_COUNT - 1);
				x = hot_x[h];
				y = hot_y[h];
			end else begin
				x = pick_axis(int'(clip_mirror.left), int'(clip_mirror.right), FRAME_WIDTH);
				y = pick_axis(int'(clip_mirror.top), int'(clip_mirror.bottom), FRAME_HEIGHT);
			end
			colour = $urandom;
			case ($urandom_range(0, 7))
				0: colour[31:24] = 8'h00;
				1: colour[31:24] = 8'hff;
				default: ;
			endcase
			send_draw(kind, x, y, colour, 1'b0, '0);
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// Result side: random stall before each transfer, then compare.
	initial begin : result_sink
		int stall;
		pix_res_t want;
		@(posedge arst_n);
		forever begin
			stall = snk_steady ? 0 : $urandom_range(0, GAP_MAX);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			if (pix_expect_q.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, '0);
			end else begin
				want = pix_expect_q.pop_front();
				if (m_axis_tdata !== want.pixel)
					report_mismatch("pixel", m_axis_tdata, want.pixel);
				if (m_axis_tuser !== want.clipped)
					report_mismatch("clipped", PIX_W'(m_axis_tuser), PIX_W'(want.clipped));
			end
		end
	end

	// Watchdog: too long without any transfer ends the run.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin : main_seq
		int cl, ct;
		clip_mirror = '{left: 9'd0, top: 9'd0, right: 9'd256, bottom: 9'd256};
		for (int i = 0; i < STORE_DEPTH; i++)
			frame_mirror[i] = '0;
		src_steady = 1'b1;
		snk_steady = 1'b1;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed table at reset clip values; first item waits out the clear
		for (int i = 0; i < DIR_COUNT; i++)
			send_draw(dir_tab[i].kind, dir_tab[i].x, dir_tab[i].y, dir_tab[i].colour,
				dir_tab[i].typed,
				'{pixel: dir_tab[i].exp_pixel, clipped: dir_tab[i].exp_clipped});
		s_axis_tvalid <= 1'b0;

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: program_clip(0, 0, FRAME_WIDTH, FRAME_HEIGHT);  // reset values
				1: program_clip(0, 0, 511, 511);                   // wider than frame
				2: program_clip(511, 511, 0, 0);                   // inverted
				3: program_clip(100, 100, 100, 100);               // empty
				4: program_clip(255, 255, 256, 256);               // last pixel only
				5, 6: begin
					cl = $urandom_range(0, 200);
					ct = $urandom_range(0, 200);
					program_clip(cl, ct, cl + $urandom_range(1, 80), ct + $urandom_range(1, 80));
				end
				default: program_clip($urandom_range(0, 511), $urandom_range(0, 511),
					$urandom_range(0, 511), $urandom_range(0, 511));
			endcase
			src_steady = ($urandom_range(0, 3) == 0);
			snk_steady = ($urandom_range(0, 3) == 0);
			run_phase(PHASE_ITEMS);
		end

		while (pix_expect_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: sim.f
rtl/cfb_pkg.sv
rtl/cfb_ram.sv
rtl/cfb_cfg.sv
rtl/cfb_blend.sv
rtl/clipped_framebuffer_alpha_blender_top.sv
tb/clipped_framebuffer_alpha_blender_top_tb.sv
